### hw/rtl/mdlc_pkg.sv
// Shared types, constants and character helpers for the Markdown line classifier.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package mdlc_pkg;

   localparam int RUN_W  = 8;
   localparam int LINE_W = 16;

   localparam logic [RUN_W-1:0]  RUN_MAX  = 8'd255;
   localparam logic [LINE_W-1:0] LINE_MAX = 16'd65535;

   localparam logic [RUN_W-1:0] FENCE_MIN = 8'd3;
   localparam logic [RUN_W-1:0] HEAD_MAX  = 8'd6;
   localparam logic [1:0]       LEAD_MAX  = 2'd3;
   localparam logic [1:0]       BREAK_MIN = 2'd3;

   localparam logic [7:0] CH_BACKTICK   = 8'h60;
   localparam logic [7:0] CH_TILDE      = 8'h7E;
   localparam logic [7:0] CH_HASH       = 8'h23;
   localparam logic [7:0] CH_DASH       = 8'h2D;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;

   localparam logic [2:0] CLS_PLAIN   = 3'd0;
   localparam logic [2:0] CLS_OPEN    = 3'd1;
   localparam logic [2:0] CLS_BODY    = 3'd2;
   localparam logic [2:0] CLS_CLOSE   = 3'd3;
   localparam logic [2:0] CLS_BREAK   = 3'd4;
   localparam logic [2:0] CLS_HEADING = 3'd5;

   // candidate flag bit positions
   localparam int CAND_OPEN  = 0;
   localparam int CAND_CLOSE = 1;
   localparam int CAND_BREAK = 2;
   localparam int CAND_HEAD  = 3;

   typedef enum logic [2:0] {
      MK_NONE,
      MK_BACKTICK,
      MK_TILDE,
      MK_HASH,
      MK_DASH,
      MK_STAR,
      MK_UNDERSCORE,
      MK_OTHER
   } marker_type;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_RUN,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]        line_class;
      logic [2:0]        heading_level;
      logic [LINE_W-1:0] line_length;
      logic [RUN_W-1:0]  fence_run;
   } rsp_type;

   function automatic marker_type marker_code(input logic [7:0] c);
      marker_type m;
      case (c)
         CH_BACKTICK:   m = MK_BACKTICK;
         CH_TILDE:      m = MK_TILDE;
         CH_HASH:       m = MK_HASH;
         CH_DASH:       m = MK_DASH;
         CH_STAR:       m = MK_STAR;
         CH_UNDERSCORE: m = MK_UNDERSCORE;
         default:       m = MK_OTHER;
      endcase
      return m;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_break_marker(input marker_type m);
      return (m == MK_DASH) || (m == MK_STAR) || (m == MK_UNDERSCORE);
   endfunction

endpackage

### hw/rtl/mdlc_in_stage.sv
// Input register for text bytes; holds one request until the scanner takes it.
// Depends on mdlc_pkg.
`timescale 1ns / 1ps

module mdlc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mdlc_pkg::req_type req_data,
   output logic             in_valid,
   output mdlc_pkg::req_type in_data,
   input  logic             in_take
);
   import mdlc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   assign req_stall = valid_ff && !in_take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !in_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

### hw/rtl/mdlc_scanner.sv
// Per-byte line scan state, fence tracking, line classification and result register.
// Depends on mdlc_pkg.
`timescale 1ns / 1ps

module mdlc_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  mdlc_pkg::req_type in_data,
   output logic              in_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mdlc_pkg::rsp_type rsp_data
);
   import mdlc_pkg::*;

   logic              fence_ff,  fence_in;
   logic              tilde_ff,  tilde_in;
   logic [RUN_W-1:0]  open_ff,   open_in;
   logic [LINE_W-1:0] bytes_ff,  bytes_in;
   logic [1:0]        lead_ff,   lead_in;
   phase_type         phase_ff,  phase_in;
   marker_type        first_ff,  first_in;
   logic [RUN_W-1:0]  run_ff,    run_in;
   logic [1:0]        brk_ff,    brk_in;
   logic [3:0]        cand_ff,   cand_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;

   logic [7:0] c;
   marker_type m;
   logic       ws;
   logic       line_end;
   logic       rsp_load;

   assign c        = in_data.text_byte;
   assign m        = marker_code(c);
   assign ws       = is_ws(c);
   assign line_end = (c == CH_LF) || in_data.last_byte;
   assign in_take  = in_valid && (!line_end || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      marker_type fence_mk;
      logic       do_trail;

      fence_in    = fence_ff;
      tilde_in    = tilde_ff;
      open_in     = open_ff;
      bytes_in    = bytes_ff;
      lead_in     = lead_ff;
      phase_in    = phase_ff;
      first_in    = first_ff;
      run_in      = run_ff;
      brk_in      = brk_ff;
      cand_in     = cand_ff;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      fence_mk    = tilde_ff ? MK_TILDE : MK_BACKTICK;
      do_trail    = 1'b0;

      if (in_take) begin
         if (bytes_ff != LINE_MAX) begin
            bytes_in = bytes_ff + 1'b1;
         end

         case (phase_ff)
            PH_LEAD: begin
               if (c == CH_SPACE && lead_ff != LEAD_MAX) begin
                  lead_in = lead_ff + 2'd1;
               end else begin
                  first_in = m;
                  run_in   = {{(RUN_W-1){1'b0}}, 1'b1};
                  brk_in   = is_break_marker(m) ? 2'd1 : 2'd0;
                  phase_in = PH_RUN;
               end
            end
            PH_RUN: begin
               if (first_ff != MK_OTHER && m == first_ff) begin
                  if (run_ff != RUN_MAX) begin
                     run_in = run_ff + 1'b1;
                  end
                  if (brk_ff != BREAK_MIN) begin
                     brk_in = brk_ff + 2'd1;
                  end
               end else begin
                  if (!ws) begin
                     cand_in[CAND_HEAD] = 1'b0;
                  end
                  phase_in = PH_TRAIL;
                  do_trail = 1'b1;
               end
            end
            PH_TRAIL: begin
               do_trail = 1'b1;
            end
            default: begin
               phase_in = PH_LEAD;
            end
         endcase

         if (do_trail) begin
            if (first_ff == MK_BACKTICK && m == MK_BACKTICK) begin
               cand_in[CAND_OPEN] = 1'b0;
            end
            if (!ws) begin
               cand_in[CAND_CLOSE] = 1'b0;
            end
            if (m == first_ff) begin
               if (brk_ff != BREAK_MIN) begin
                  brk_in = brk_ff + 2'd1;
               end
            end else if (!ws) begin
               cand_in[CAND_BREAK] = 1'b0;
            end
         end

         if (line_end) begin
            rsp_load                = 1'b1;
            rsp_data_in.line_class  = CLS_PLAIN;
            rsp_data_in.line_length = bytes_in;

            if (fence_ff) begin
               if (first_in == fence_mk && run_in >= open_ff && cand_in[CAND_CLOSE]) begin
                  rsp_data_in.line_class = CLS_CLOSE;
                  fence_in               = 1'b0;
               end else begin
                  rsp_data_in.line_class = CLS_BODY;
               end
            end else if ((first_in == MK_BACKTICK || first_in == MK_TILDE) &&
                         run_in >= FENCE_MIN &&
                         (first_in == MK_TILDE || cand_in[CAND_OPEN])) begin
               rsp_data_in.line_class = CLS_OPEN;
               rsp_data_in.fence_run  = run_in;
               fence_in               = 1'b1;
               tilde_in               = (first_in == MK_TILDE);
               open_in                = run_in;
            end else if (is_break_marker(first_in) && cand_in[CAND_BREAK] &&
                         brk_in == BREAK_MIN) begin
               rsp_data_in.line_class = CLS_BREAK;
            end else if (first_in == MK_HASH && run_in <= HEAD_MAX && cand_in[CAND_HEAD]) begin
               rsp_data_in.line_class    = CLS_HEADING;
               rsp_data_in.heading_level = run_in[2:0];
            end

            bytes_in = '0;
            lead_in  = '0;
            phase_in = PH_LEAD;
            first_in = MK_NONE;
            run_in   = '0;
            brk_in   = '0;
            cand_in  = '1;
            if (in_data.last_byte) begin
               fence_in = 1'b0;
               tilde_in = 1'b0;
               open_in  = '0;
            end
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fence_ff     <= 1'b0;
         tilde_ff     <= 1'b0;
         open_ff      <= '0;
         bytes_ff     <= '0;
         lead_ff      <= '0;
         phase_ff     <= PH_LEAD;
         first_ff     <= MK_NONE;
         run_ff       <= '0;
         brk_ff       <= '0;
         cand_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         fence_ff     <= fence_in;
         tilde_ff     <= tilde_in;
         open_ff      <= open_in;
         bytes_ff     <= bytes_in;
         lead_ff      <= lead_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         run_ff       <= run_in;
         brk_ff       <= brk_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/markdown_block_line_classifier.sv
// Markdown block line classifier: one text byte per request, one response per line.
// A line's ending byte passes the input register, then the scanner's response register.
// Throughput: one byte per cycle; only a line-ending byte waits while a response is stalled.
// Reset (synchronous, active high) clears fence and line state and empties both registers.
// Depends on mdlc_pkg, mdlc_in_stage, mdlc_scanner.
`timescale 1ns / 1ps

module markdown_block_line_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mdlc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mdlc_pkg::rsp_type rsp_data
);
   import mdlc_pkg::*;

   logic    in_valid;
   req_type in_data;
   logic    in_take;

   mdlc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .in_valid  (in_valid),
      .in_data   (in_data),
      .in_take   (in_take)
   );

   mdlc_scanner u_scanner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_data   (in_data),
      .in_take   (in_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_stall_needs_held_req: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid)
      else $error("request stalled with empty input register");

   a_level_only_on_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.line_class == CLS_HEADING) == (rsp_data.heading_level != 3'd0)))
      else $error("heading level does not match line class");

   a_run_only_on_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fence_run != '0) |->
         (rsp_data.line_class == CLS_OPEN && rsp_data.fence_run >= FENCE_MIN))
      else $error("fence run reported outside a fence open line");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

### dv/tb_markdown_block_line_classifier.sv
// Testbench for markdown_block_line_classifier: streams directed and random Markdown text
// bytes, predicts each line's class in a scoreboard class and checks every response.
// Depends on mdlc_pkg and the markdown_block_line_classifier RTL.
`timescale 1ns / 1ps

import mdlc_pkg::*;

class line_scoreboard;
   rsp_type    expected_lines[$];
   int         errors;

   bit         fence_active;
   bit         fence_tilde;
   logic [7:0] open_len;
   logic [15:0] line_len;
   logic [1:0] lead;
   phase_type  scan_state;
   marker_type first_mk;
   logic [7:0] run;
   logic [1:0] brk;
   logic [3:0] cand;

   function new();
      errors = 0;
      fence_active = 1'b0;
      fence_tilde = 1'b0;
      open_len = '0;
      clear_line();
   endfunction

   function void clear_line();
      line_len = '0;
      lead = '0;
      scan_state = PH_LEAD;
      first_mk = MK_NONE;
      run = '0;
      brk = '0;
      cand = 4'hF;
   endfunction

   function marker_type char_marker(logic [7:0] c);
      case (c)
         CH_BACKTICK:   return MK_BACKTICK;
         CH_TILDE:      return MK_TILDE;
         CH_HASH:       return MK_HASH;
         CH_DASH:       return MK_DASH;
         CH_STAR:       return MK_STAR;
         CH_UNDERSCORE: return MK_UNDERSCORE;
         default:       return MK_OTHER;
      endcase
   endfunction

   function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function bit rule_marker(marker_type m);
      return m == MK_DASH || m == MK_STAR || m == MK_UNDERSCORE;
   endfunction

   function void after_run(logic [7:0] c, marker_type m);
      if (first_mk == MK_BACKTICK && m == MK_BACKTICK) cand[CAND_OPEN] = 1'b0;
      if (!is_blank(c)) cand[CAND_CLOSE] = 1'b0;
      if (m == first_mk) begin
         if (brk != BREAK_MIN) brk++;
      end else if (!is_blank(c)) begin
         cand[CAND_BREAK] = 1'b0;
      end
   endfunction

   function void note_request(req_type r);
      logic [7:0] c;
      marker_type m;
      rsp_type    e;
      c = r.text_byte;
      m = char_marker(c);
      if (line_len != LINE_MAX) line_len++;
      case (scan_state)
         PH_LEAD: begin
            if (c == CH_SPACE && lead != LEAD_MAX) begin
               lead++;
            end else begin
               first_mk = m;
               run = 8'd1;
               brk = rule_marker(m) ? 2'd1 : 2'd0;
               scan_state = PH_RUN;
            end
         end
         PH_RUN: begin
            if (first_mk != MK_OTHER && m == first_mk) begin
               if (run != RUN_MAX) run++;
               if (brk != BREAK_MIN) brk++;
            end else begin
               if (!is_blank(c)) cand[CAND_HEAD] = 1'b0;
               scan_state = PH_TRAIL;
               after_run(c, m);
            end
         end
         default: after_run(c, m);
      endcase
      if (c != CH_LF && !r.last_byte) return;

      e = '0;
      e.line_length = line_len;
      if (fence_active) begin
         if (first_mk == (fence_tilde ? MK_TILDE : MK_BACKTICK) && run >= open_len &&
             cand[CAND_CLOSE]) begin
            e.line_class = CLS_CLOSE;
            fence_active = 1'b0;
         end else begin
            e.line_class = CLS_BODY;
         end
      end else if ((first_mk == MK_BACKTICK || first_mk == MK_TILDE) && run >= FENCE_MIN &&
                   (first_mk == MK_TILDE || cand[CAND_OPEN])) begin
         e.line_class = CLS_OPEN;
         e.fence_run = run;
         fence_active = 1'b1;
         fence_tilde = (first_mk == MK_TILDE);
         open_len = run;
      end else if (rule_marker(first_mk) && cand[CAND_BREAK] && brk >= BREAK_MIN) begin
         e.line_class = CLS_BREAK;
      end else if (first_mk == MK_HASH && run <= HEAD_MAX && cand[CAND_HEAD]) begin
         e.line_class = CLS_HEADING;
         e.heading_level = run[2:0];
      end else begin
         e.line_class = CLS_PLAIN;
      end
      expected_lines.push_back(e);
      clear_line();
      if (r.last_byte) begin
         fence_active = 1'b0;
         fence_tilde = 1'b0;
         open_len = '0;
      end
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (expected_lines.size() == 0) begin
         $error("unexpected line response: line_class %0d line_length %0d",
                got.line_class, got.line_length);
         errors++;
         return;
      end
      want = expected_lines.pop_front();
      if (got.line_class !== want.line_class) begin
         $error("line_class expected %0d actual %0d", want.line_class, got.line_class);
         errors++;
      end
      if (got.heading_level !== want.heading_level) begin
         $error("heading_level expected %0d actual %0d", want.heading_level, got.heading_level);
         errors++;
      end
      if (got.line_length !== want.line_length) begin
         $error("line_length expected %0d actual %0d", want.line_length, got.line_length);
         errors++;
      end
      if (got.fence_run !== want.fence_run) begin
         $error("fence_run expected %0d actual %0d", want.fence_run, got.fence_run);
         errors++;
      end
   endfunction

   function int pending();
      return expected_lines.size();
   endfunction
endclass

module tb_markdown_block_line_classifier;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   line_scoreboard sb = new();
   logic [7:0]     text_q[$];
   int             idle_pct = 0;
   int             stall_pct = 0;
   int             bytes_sent = 0;

   markdown_block_line_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   task automatic send_request(input logic [7:0] c, input logic lst);
      req_type r;
      int      gap;
      r.text_byte = c;
      r.last_byte = lst;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      bytes_sent++;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic emit(input bit mark_last);
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) send_request(text_q[i], mark_last && (i == n - 1));
      text_q.delete();
   endtask

   // hold off requests until every predicted line has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void put_run(input logic [7:0] c, input int n);
      repeat (n) text_q.push_back(c);
   endfunction

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic void put_word(input int n);
      repeat (n) text_q.push_back(8'($urandom_range(33, 126)));
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_CR;
      endcase
   endfunction

   task automatic random_line();
      logic [7:0] c;
      int         kind;
      kind = $urandom_range(11);
      if ($urandom_range(5) == 0) put_run(CH_TAB, 1);
      else put_run(CH_SPACE, $urandom_range(4));
      case (kind)
         0, 1, 2: begin
            c = $urandom_range(1) ? CH_BACKTICK : CH_TILDE;
            put_run(c, $urandom_range(2, 6));
            case ($urandom_range(3))
               0: put_word($urandom_range(1, 5));
               1: put_run(pick_blank(), $urandom_range(1, 2));
               2: begin
                  put_word(1);
                  put_run($urandom_range(1) ? CH_BACKTICK : CH_TILDE, 1);
               end
               default: ;
            endcase
         end
         3, 4: begin
            case ($urandom_range(2))
               0:       c = CH_DASH;
               1:       c = CH_STAR;
               default: c = CH_UNDERSCORE;
            endcase
            repeat ($urandom_range(2, 5)) begin
               put_run(c, 1);
               if ($urandom_range(2) == 0) put_run(pick_blank(), 1);
               if ($urandom_range(9) == 0) put_word(1);
            end
         end
         5, 6: begin
            put_run(CH_HASH, $urandom_range(1, 8));
            case ($urandom_range(3))
               0: begin
                  put_run(pick_blank(), 1);
                  put_word($urandom_range(1, 5));
               end
               1: put_word($urandom_range(1, 3));
               2: put_run(CH_TAB, 1);
               default: ;
            endcase
         end
         7, 8: put_word($urandom_range(1, 8));
         9: repeat ($urandom_range(1, 4)) put_run(pick_blank(), 1);
         default: repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(255)));
      endcase
      if ($urandom_range(19) == 0) begin
         if ($urandom_range(1)) put_run(CH_LF, 1);
         emit(1'b1);
      end else begin
         put_run(CH_LF, 1);
         emit(1'b0);
      end
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_stall, input int n_bytes);
      int start;
      start = bytes_sent;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      while (bytes_sent - start < n_bytes) random_line();
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      put_str("# Title\n###### six\n####### seven\n#tag\n##\n   ## x\n    # x\n");
      put_str("---\n* * *\n_ _\t_ \n--\n***x\n\n \t \n");
      emit(1'b0);
      put_run(CH_BACKTICK, 3); put_str("c\nbody\n  ");
      put_run(CH_BACKTICK, 2); put_str("\n");
      put_run(CH_BACKTICK, 4); put_str("\n");
      put_run(CH_BACKTICK, 3); put_str(" a");
      put_run(CH_BACKTICK, 1); put_str("b\n");
      put_run(CH_TILDE, 4); put_str(" x");
      put_run(CH_BACKTICK, 1); put_str("y\n");
      put_run(CH_TILDE, 3); put_str("\n");
      put_run(CH_BACKTICK, 4); put_str("\n");
      put_run(CH_TILDE, 5); put_str(" "); put_run(CH_CR, 1); put_str("\n");
      put_run(CH_BACKTICK, 3); put_str("x\n");
      put_run(CH_BACKTICK, 3); put_str(" y\n");
      put_run(CH_BACKTICK, 3); put_str("\n");
      put_run(CH_TILDE, 3); put_str("\ninside");
      emit(1'b1);
      put_str("---\n");
      emit(1'b0);
      put_str("# end");
      emit(1'b1);
      put_str("##");
      emit(1'b1);
      put_str("text\n");
      emit(1'b1);
      drain();

      run_phase(0, 0, 85);
      run_phase(79, 0, 85);
      run_phase(0, 79, 85);
      run_phase(25, 25, 85);
      idle_pct = 0;
      stall_pct = 0;
      repeat (10) @(posedge clock);

      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### markdown_block_line_classifier.f
hw/rtl/mdlc_pkg.sv
hw/rtl/mdlc_in_stage.sv
hw/rtl/mdlc_scanner.sv
hw/rtl/markdown_block_line_classifier.sv
dv/tb_markdown_block_line_classifier.sv
